// ----- rtl/core/ppa_pkg.sv -----
// ppa_pkg: shared codes and word types for the parallel port adapter
// no dependencies; used by the channel interfaces and the core

package ppa_pkg;

    typedef logic [2:0] action_t;
    typedef logic [1:0] reg_sel_t;

    localparam action_t ACT_READ  = 3'd0;
    localparam action_t ACT_WRITE = 3'd1;
    localparam action_t ACT_LINE_A = 3'd2;
    localparam action_t ACT_LINE_B = 3'd3;
    localparam action_t ACT_PEEK  = 3'd4;

    localparam reg_sel_t RS_DATA_A = 2'd0;
    localparam reg_sel_t RS_CTRL_A = 2'd1;
    localparam reg_sel_t RS_DATA_B = 2'd2;
    localparam reg_sel_t RS_CTRL_B = 2'd3;

    localparam int CTRL_W = 6;

    localparam int CTRL_DIR_SEL_BIT  = 2;
    localparam int CTRL_EDGE_SEL_BIT = 1;
    localparam int CTRL_IRQ_EN_BIT   = 0;

    typedef logic [CTRL_W-1:0] ctrl_t;

    typedef struct packed {
        action_t    action;
        reg_sel_t   reg_select;
        logic [7:0] write_data;
        logic       line_level;
        logic [7:0] port_a_in;
        logic [7:0] port_b_in;
    } req_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_drive;
        logic       port_a_update;
        logic [7:0] port_b_drive;
        logic       port_b_update;
        logic       irq_level;
        logic       irq_changed;
    } rsp_word_t;

    function automatic logic [7:0] pin_value(input logic [7:0] o, input logic [7:0] d,
                                             input logic [7:0] ext);
        pin_value = (o & d) | (ext & ~d);
    endfunction

    function automatic logic [7:0] drive_value(input logic [7:0] o, input logic [7:0] d);
        drive_value = (o & d) | ~d;
    endfunction

    function automatic logic edge_seen(input ctrl_t ctrl, input logic last, input logic now);
        if (ctrl[CTRL_EDGE_SEL_BIT])
            edge_seen = !last && now;
        else
            edge_seen = last && !now;
    endfunction

endpackage

// ----- rtl/core/ppa_if.sv -----
// ppa_req_if and ppa_rsp_if: valid/ready channels carrying request and result words
// depends on ppa_pkg for the word types

interface ppa_req_if;
    import ppa_pkg::*;

    logic      valid;
    logic      ready;
    req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppa_rsp_if;
    import ppa_pkg::*;

    logic      valid;
    logic      ready;
    rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/parallel_port_adapter_with_irq.sv -----
// parallel_port_adapter_with_irq: two-port parallel adapter with edge flags and irq
// path: a word accepted is held in the input register, then its result in the result
// register; throughput: one word per cycle while results are taken, set by the single
// update of the port state between the two registers; the input register takes a word
// while a result waits only when it is empty; rst_n clears all port state and empties
// both stages asynchronously; depends on ppa_pkg and ppa_if

module parallel_port_adapter_with_irq (
    input logic     clk,
    input logic     rst_n,
    ppa_req_if.sink req,
    ppa_rsp_if.source rsp
);
    import ppa_pkg::*;

    logic       stage_valid_reg;
    req_word_t  stage_word_reg;
    logic       rsp_valid_reg;
    rsp_word_t  rsp_word_reg;

    logic [7:0] out_a_reg, dir_a_reg, out_b_reg, dir_b_reg;
    ctrl_t      ctrl_a_reg, ctrl_b_reg;
    logic       line_a_reg, line_b_reg, flag_a_reg, flag_b_reg, irq_out_reg;

    logic [7:0] out_a_next, dir_a_next, out_b_next, dir_b_next;
    ctrl_t      ctrl_a_next, ctrl_b_next;
    logic       line_a_next, line_b_next, flag_a_next, flag_b_next, irq_out_next;
    rsp_word_t  rsp_word_next;

    logic       rsp_load;
    logic       req_take;
    logic       is_read;
    logic       upd_a, upd_b;
    logic [7:0] rd;

    assign rsp_load  = !rsp_valid_reg || rsp.ready;
    assign req.ready = !stage_valid_reg || rsp_load;
    assign req_take  = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_word_reg;

    always_comb
    begin
        out_a_next  = out_a_reg;
        dir_a_next  = dir_a_reg;
        ctrl_a_next = ctrl_a_reg;
        out_b_next  = out_b_reg;
        dir_b_next  = dir_b_reg;
        ctrl_b_next = ctrl_b_reg;
        line_a_next = line_a_reg;
        line_b_next = line_b_reg;
        flag_a_next = flag_a_reg;
        flag_b_next = flag_b_reg;
        upd_a       = 1'b0;
        upd_b       = 1'b0;
        rd          = 8'h00;
        is_read     = (stage_word_reg.action == ACT_READ);

        case (stage_word_reg.action) inside
            ACT_READ, ACT_PEEK:
            begin
                unique case (stage_word_reg.reg_select)
                    RS_DATA_A:
                    begin
                        if (!ctrl_a_reg[CTRL_DIR_SEL_BIT])
                            rd = dir_a_reg;
                        else
                        begin
                            rd = pin_value(out_a_reg, dir_a_reg, stage_word_reg.port_a_in);
                            if (is_read)
                                flag_a_next = 1'b0;
                        end
                    end
                    RS_CTRL_A: rd = {flag_a_reg, 1'b0, ctrl_a_reg};
                    RS_DATA_B:
                    begin
                        if (!ctrl_b_reg[CTRL_DIR_SEL_BIT])
                            rd = dir_b_reg;
                        else
                        begin
                            rd = pin_value(out_b_reg, dir_b_reg, stage_word_reg.port_b_in);
                            if (is_read)
                                flag_b_next = 1'b0;
                        end
                    end
                    RS_CTRL_B: rd = {flag_b_reg, 1'b0, ctrl_b_reg};
                    default:   rd = 8'h00;
                endcase
            end
            ACT_WRITE:
            begin
                unique case (stage_word_reg.reg_select)
                    RS_DATA_A:
                    begin
                        if (ctrl_a_reg[CTRL_DIR_SEL_BIT])
                        begin
                            out_a_next = stage_word_reg.write_data;
                            upd_a      = 1'b1;
                        end
                        else
                            dir_a_next = stage_word_reg.write_data;
                    end
                    RS_CTRL_A: ctrl_a_next = stage_word_reg.write_data[CTRL_W-1:0];
                    RS_DATA_B:
                    begin
                        if (ctrl_b_reg[CTRL_DIR_SEL_BIT])
                        begin
                            out_b_next = stage_word_reg.write_data;
                            upd_b      = 1'b1;
                        end
                        else
                            dir_b_next = stage_word_reg.write_data;
                    end
                    RS_CTRL_B: ctrl_b_next = stage_word_reg.write_data[CTRL_W-1:0];
                    default:   ctrl_b_next = ctrl_b_reg;
                endcase
            end
            ACT_LINE_A:
            begin
                if (edge_seen(ctrl_a_reg, line_a_reg, stage_word_reg.line_level))
                    flag_a_next = 1'b1;
                line_a_next = stage_word_reg.line_level;
            end
            ACT_LINE_B:
            begin
                if (edge_seen(ctrl_b_reg, line_b_reg, stage_word_reg.line_level))
                    flag_b_next = 1'b1;
                line_b_next = stage_word_reg.line_level;
            end
            default:
            begin
                rd = 8'h00;
            end
        endcase

        irq_out_next = (flag_a_next && ctrl_a_next[CTRL_IRQ_EN_BIT]) ||
                       (flag_b_next && ctrl_b_next[CTRL_IRQ_EN_BIT]);

        rsp_word_next.read_data     = rd;
        rsp_word_next.port_a_drive  = drive_value(out_a_next, dir_a_next);
        rsp_word_next.port_a_update = upd_a;
        rsp_word_next.port_b_drive  = drive_value(out_b_next, dir_b_next);
        rsp_word_next.port_b_update = upd_b;
        rsp_word_next.irq_level     = irq_out_next;
        rsp_word_next.irq_changed   = irq_out_next != irq_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            out_a_reg       <= 8'h00;
            dir_a_reg       <= 8'h00;
            ctrl_a_reg      <= '0;
            out_b_reg       <= 8'h00;
            dir_b_reg       <= 8'h00;
            ctrl_b_reg      <= '0;
            line_a_reg      <= 1'b0;
            line_b_reg      <= 1'b0;
            flag_a_reg      <= 1'b0;
            flag_b_reg      <= 1'b0;
            irq_out_reg     <= 1'b0;
        end
        else
        begin
            if (req.ready)
                stage_valid_reg <= req.valid;
            if (rsp_load)
            begin
                rsp_valid_reg <= stage_valid_reg;
                if (stage_valid_reg)
                begin
                    out_a_reg   <= out_a_next;
                    dir_a_reg   <= dir_a_next;
                    ctrl_a_reg  <= ctrl_a_next;
                    out_b_reg   <= out_b_next;
                    dir_b_reg   <= dir_b_next;
                    ctrl_b_reg  <= ctrl_b_next;
                    line_a_reg  <= line_a_next;
                    line_b_reg  <= line_b_next;
                    flag_a_reg  <= flag_a_next;
                    flag_b_reg  <= flag_b_next;
                    irq_out_reg <= irq_out_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            stage_word_reg <= req.data;
        if (rsp_load && stage_valid_reg)
            rsp_word_reg <= rsp_word_next;
    end

    // pending result always matches the committed irq state
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.data.irq_level == irq_out_reg)
        else $error("irq level in result differs from irq state");

    // input pins of port a always drive high in a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.data.port_a_drive | dir_a_reg) == 8'hff)
        else $error("port a drive not pulled high on input bits");

    // full pipe with a stalled result refuses new words
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("word accepted while both stages are full");

    // an output register write never returns read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.data.port_a_update || rsp.data.port_b_update))
            |-> rsp.data.read_data == 8'h00)
        else $error("read data on a write result");

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for parallel_port_adapter_with_irq, driving request words and
// scoring result words against a cycle-free predictor of the two ports and irq or fixed
// words for typed opening rows; depends on ppa_pkg, ppa_req_if / ppa_rsp_if and the adapter rtl

`timescale 1ns / 1ps

module tb;
    import ppa_pkg::*;

    localparam action_t ACT_SPARE_LO  = 3'd5;
    localparam action_t ACT_SPARE_HI  = 3'd7;
    localparam int      RANDOM_PHASES = 4;
    localparam int      PHASE_WORDS   = 270;
    localparam int      HOLD_CYCLES   = 40;
    localparam int      DRAIN_CYCLES  = 8;
    localparam int      CYCLE_LIMIT   = 400000;
    localparam int      MAX_REPORTS   = 10;

    typedef struct {
        logic [7:0] out_r;
        logic [7:0] dir_r;
        ctrl_t      ctrl;
        logic       line_last;
        logic       flag;
    } port_state_t;

    typedef struct {
        req_word_t w;
        bit        typed;
        rsp_word_t exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ppa_req_if req_ch ();
    ppa_rsp_if rsp_ch ();

    parallel_port_adapter_with_irq dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    port_state_t port_a;
    port_state_t port_b;
    logic        irq_line;
    rsp_word_t   port_results_due[$];
    stim_row_t   opening_words[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_pending;
    int hold_taken;
    int hold_left;
    int cycle_count;
    int words_sent;
    int results_checked;
    int mismatches;
    int line_words;
    int fetch_words;
    int irq_toggles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] port_fetch(inout port_state_t p, input logic [7:0] ext,
                                              input bit data_addr, input bit consume);
        if (!data_addr)
            return {p.flag, 1'b0, p.ctrl};
        if (!p.ctrl[CTRL_DIR_SEL_BIT])
            return p.dir_r;
        if (consume)
            p.flag = 1'b0;
        return (p.out_r & p.dir_r) | (ext & ~p.dir_r);
    endfunction

    function automatic void port_store(inout port_state_t p, input bit data_addr,
                                       input logic [7:0] wd, output logic upd);
        upd = 1'b0;
        if (!data_addr)
            p.ctrl = wd[CTRL_W-1:0];
        else if (p.ctrl[CTRL_DIR_SEL_BIT])
        begin
            p.out_r = wd;
            upd = 1'b1;
        end
        else
            p.dir_r = wd;
    endfunction

    function automatic void port_line(inout port_state_t p, input logic lvl);
        if (p.ctrl[CTRL_EDGE_SEL_BIT] ? (!p.line_last && lvl) : (p.line_last && !lvl))
            p.flag = 1'b1;
        p.line_last = lvl;
    endfunction

    function automatic rsp_word_t compute_port_result(req_word_t w);
        rsp_word_t r;
        logic      irq_next;
        bit        data_addr;
        bit        on_b;
        r = '0;
        data_addr = (w.reg_select == RS_DATA_A) || (w.reg_select == RS_DATA_B);
        on_b = (w.reg_select == RS_DATA_B) || (w.reg_select == RS_CTRL_B);
        case (w.action) inside
            ACT_READ, ACT_PEEK:
                if (on_b)
                    r.read_data = port_fetch(port_b, w.port_b_in, data_addr,
                                             w.action == ACT_READ);
                else
                    r.read_data = port_fetch(port_a, w.port_a_in, data_addr,
                                             w.action == ACT_READ);
            ACT_WRITE:
                if (on_b)
                    port_store(port_b, data_addr, w.write_data, r.port_b_update);
                else
                    port_store(port_a, data_addr, w.write_data, r.port_a_update);
            ACT_LINE_A:
                port_line(port_a, w.line_level);
            ACT_LINE_B:
                port_line(port_b, w.line_level);
            default:
                ;
        endcase
        r.port_a_drive = (port_a.out_r & port_a.dir_r) | ~port_a.dir_r;
        r.port_b_drive = (port_b.out_r & port_b.dir_r) | ~port_b.dir_r;
        irq_next = (port_a.flag && port_a.ctrl[CTRL_IRQ_EN_BIT]) ||
                   (port_b.flag && port_b.ctrl[CTRL_IRQ_EN_BIT]);
        r.irq_level = irq_next;
        r.irq_changed = irq_next != irq_line;
        irq_line = irq_next;
        return r;
    endfunction

    function automatic stim_row_t opening_row(action_t a, reg_sel_t rs, logic [7:0] wd,
                                              logic lvl, logic [7:0] ain, logic [7:0] bin,
                                              bit typed, rsp_word_t exp);
        stim_row_t s;
        s.w = '{action: a, reg_select: rs, write_data: wd, line_level: lvl,
                port_a_in: ain, port_b_in: bin};
        s.typed = typed;
        s.exp = exp;
        return s;
    endfunction

    function automatic req_word_t random_word();
        req_word_t w;
        int        pick;
        pick = $urandom_range(99);
        w.reg_select = reg_sel_t'($urandom_range(3));
        w.write_data = 8'($urandom_range(255));
        w.line_level = 1'($urandom_range(1));
        w.port_a_in = 8'($urandom_range(255));
        w.port_b_in = 8'($urandom_range(255));
        if (pick < 25)
            w.action = ACT_READ;
        else if (pick < 60)
            w.action = ACT_WRITE;
        else if (pick < 72)
            w.action = ACT_LINE_A;
        else if (pick < 84)
            w.action = ACT_LINE_B;
        else if (pick < 96)
            w.action = ACT_PEEK;
        else
            w.action = action_t'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        return w;
    endfunction

    function automatic string show(rsp_word_t r);
        return $sformatf("rd=%02h a=%02h/%0b b=%02h/%0b irq=%0b chg=%0b", r.read_data,
                         r.port_a_drive, r.port_a_update, r.port_b_drive, r.port_b_update,
                         r.irq_level, r.irq_changed);
    endfunction

    task automatic push_word(input req_word_t w, input bit typed, input rsp_word_t exp);
        rsp_word_t predicted;
        req_ch.valid <= 1'b1;
        req_ch.data <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = compute_port_result(w);
        port_results_due.push_back(typed ? exp : predicted);
        words_sent++;
        if (w.action == ACT_LINE_A || w.action == ACT_LINE_B)
            line_words++;
        if (w.action == ACT_READ || w.action == ACT_PEEK)
            fetch_words++;
        if (predicted.irq_changed)
            irq_toggles++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (port_results_due.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_pending != hold_taken)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_taken <= hold_pending;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : score
        rsp_word_t exp_w;
        rsp_word_t got_w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_w = rsp_ch.data;
            if (port_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word: %s", show(got_w));
            end
            else
            begin
                exp_w = port_results_due.pop_front();
                results_checked++;
                if (got_w.read_data !== exp_w.read_data ||
                    got_w.port_a_drive !== exp_w.port_a_drive ||
                    got_w.port_a_update !== exp_w.port_a_update ||
                    got_w.port_b_drive !== exp_w.port_b_drive ||
                    got_w.port_b_update !== exp_w.port_b_update ||
                    got_w.irq_level !== exp_w.irq_level ||
                    got_w.irq_changed !== exp_w.irq_changed)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d mismatch: expected %s, got %s",
                                 results_checked, show(exp_w), show(got_w));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     port_results_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_pending = 0;
        hold_taken = 0;
        hold_left = 0;
        cycle_count = 0;
        words_sent = 0;
        results_checked = 0;
        mismatches = 0;
        line_words = 0;
        fetch_words = 0;
        irq_toggles = 0;
        port_a = '{default: '0};
        port_b = '{default: '0};
        irq_line = 1'b0;

        opening_words.push_back(opening_row(ACT_PEEK, RS_DATA_A, 8'h00, 1'b0, 8'hff, 8'hff,
                                1, '{8'h00, 8'hff, 1'b0, 8'hff, 1'b0, 1'b0, 1'b0}));
        opening_words.push_back(opening_row(ACT_READ, RS_CTRL_A, 8'hff, 1'b1, 8'h00, 8'h00,
                                1, '{8'h00, 8'hff, 1'b0, 8'hff, 1'b0, 1'b0, 1'b0}));
        opening_words.push_back(opening_row(ACT_WRITE, RS_DATA_A, 8'hff, 1'b0, 8'h00, 8'h00,
                                1, '{8'h00, 8'h00, 1'b0, 8'hff, 1'b0, 1'b0, 1'b0}));
        opening_words.push_back(opening_row(ACT_WRITE, RS_CTRL_A, 8'hff, 1'b0, 8'h00, 8'h00,
                                1, '{8'h00, 8'h00, 1'b0, 8'hff, 1'b0, 1'b0, 1'b0}));
        opening_words.push_back(opening_row(ACT_READ, RS_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00,
                                1, '{8'h3f, 8'h00, 1'b0, 8'hff, 1'b0, 1'b0, 1'b0}));
        opening_words.push_back(opening_row(ACT_WRITE, RS_DATA_A, 8'ha5, 1'b0, 8'h00, 8'h00,
                                1, '{8'h00, 8'ha5, 1'b1, 8'hff, 1'b0, 1'b0, 1'b0}));
        opening_words.push_back(opening_row(ACT_READ, RS_DATA_A, 8'h00, 1'b0, 8'h5a, 8'hff,
                                0, '0));
        opening_words.push_back(opening_row(ACT_WRITE, RS_DATA_B, 8'h0f, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_WRITE, RS_CTRL_B, 8'h04, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_WRITE, RS_DATA_B, 8'hff, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_READ, RS_DATA_B, 8'h00, 1'b0, 8'hff, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_LINE_A, RS_CTRL_B, 8'hff, 1'b1, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_LINE_A, RS_DATA_A, 8'h00, 1'b1, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_PEEK, RS_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_PEEK, RS_DATA_A, 8'h00, 1'b0, 8'hff, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_READ, RS_DATA_A, 8'h00, 1'b0, 8'h00, 8'hff,
                                0, '0));
        opening_words.push_back(opening_row(ACT_LINE_B, RS_DATA_A, 8'h00, 1'b1, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_LINE_B, RS_CTRL_A, 8'hff, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_READ, RS_CTRL_B, 8'h00, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_WRITE, RS_CTRL_B, 8'h05, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_LINE_A, RS_DATA_B, 8'h00, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_SPARE_LO, RS_CTRL_B, 8'hff, 1'b1, 8'hff,
                                8'hff, 0, '0));
        opening_words.push_back(opening_row(ACT_SPARE_HI, RS_DATA_A, 8'h00, 1'b0, 8'h00,
                                8'h00, 0, '0));
        opening_words.push_back(opening_row(ACT_READ, RS_DATA_B, 8'h00, 1'b0, 8'h00, 8'h00,
                                0, '0));
        opening_words.push_back(opening_row(ACT_WRITE, RS_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00,
                                0, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_words[i])
            push_word(opening_words[i].w, opening_words[i].typed, opening_words[i].exp);
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (ph == 0 && i == 60)
                    hold_pending++;
                push_word(random_word(), 0, '0);
            end
            drain_results();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += port_results_due.size();

        $display("%0d words sent (%0d reads/peeks, %0d line events), %0d results checked",
                 words_sent, fetch_words, line_words, results_checked);
        $display("irq output toggled %0d times, %0d mismatches over %0d cycles",
                 irq_toggles, mismatches, cycle_count);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
